// ===== rtl/ffha_pkg.sv =====
`default_nettype none

package ffha_pkg;

    localparam int REQ_W    = 13;
    localparam int OFF_W    = 13;
    localparam int OUT_W    = 12;
    localparam int ALIGN_B  = 4;
    localparam int ALIGN_SH = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator over an implicit list of block headers held in a
// single-port-write, registered-read memory with one entry per 4-byte granule.
// A transaction is accepted when start is high and busy is low; its single
// result appears on ok, block_offset and merged_size for one cycle with done
// high, and the receiver cannot stall it. After reset the block runs a clearing
// pass over all HEAP_BYTES/4 header entries (1024 by default) with busy high.
// An allocate makes one memory read per header visited. A free merges the
// freed block with each free neighbor after it and stops at the end of the
// heap or at a used block. A free of a null or out-of-heap offset answers in
// the cycle after acceptance. The header memory read port bounds the rate, so
// duration grows with fragmentation.

`default_nettype none

module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              op,
    input  wire logic [ffha_pkg::REQ_W-1:0]        request_size,
    input  wire logic [ffha_pkg::OFF_W-1:0]        data_offset,
    output logic                                   done,
    output logic                                   ok,
    output logic [ffha_pkg::OUT_W-1:0]             block_offset,
    output logic [ffha_pkg::OUT_W-1:0]             merged_size
);

    localparam int GRANULES = HEAP_BYTES / ffha_pkg::ALIGN_B;
    localparam int AW       = $clog2(HEAP_BYTES);
    localparam int GW       = $clog2(GRANULES);
    localparam int SW       = AW + 1;
    localparam int EW       = SW + 1;
    localparam int PW       = (AW + 2 > 15) ? AW + 2 : 15;

    localparam logic [PW-1:0] HDR   = PW'(HEADER_BYTES);
    localparam logic [PW-1:0] HEAP  = PW'(HEAP_BYTES);
    localparam logic [PW-1:0] LIMIT = PW'(HEAP_BYTES + HEADER_BYTES);
    localparam logic [PW-1:0] RMASK = PW'(ffha_pkg::ALIGN_B - 1);
    localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [GW-1:0] LAST_IDX  = GW'(GRANULES - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_A_MARK,
        ST_F_RD,
        ST_F_HD,
        ST_F_NRD,
        ST_F_NCHK,
        ST_F_WR
    } state_t;

    state_t          state_reg, state_next;
    logic [GW-1:0]   clr_reg, clr_next;
    logic [PW-1:0]   p_reg, p_next;
    logic [PW-1:0]   nx_reg, nx_next;
    logic [PW-1:0]   need_reg, need_next;
    logic [PW-1:0]   hsize_reg, hsize_next;
    logic            done_reg, done_next;
    logic            ok_reg, ok_next;
    logic [ffha_pkg::OUT_W-1:0] boff_reg, boff_next;
    logic [ffha_pkg::OUT_W-1:0] msize_reg, msize_next;

    logic [EW-1:0]   hdr_mem_reg [GRANULES];
    logic [EW-1:0]   rd_data_reg;
    logic [GW-1:0]   rd_addr;
    logic            wr_en;
    logic [GW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;

    logic [PW-1:0]   rd_size;
    logic            rd_free;
    logic [PW-1:0]   off_al;
    logic [PW-1:0]   split_pos;
    logic [PW-1:0]   merge_size;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            hdr_mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= hdr_mem_reg[rd_addr];
    end

    assign rd_size    = PW'(rd_data_reg[SW-1:0]);
    assign rd_free    = rd_data_reg[SW];
    assign off_al     = PW'({data_offset[ffha_pkg::OFF_W-1:ffha_pkg::ALIGN_SH],
                             {ffha_pkg::ALIGN_SH{1'b0}}});
    assign split_pos  = p_reg + HDR + need_reg;
    assign merge_size = hsize_reg + HDR + rd_size;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        p_next     = p_reg;
        nx_next    = nx_reg;
        need_next  = need_reg;
        hsize_next = hsize_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        boff_next  = boff_reg;
        msize_next = msize_reg;
        rd_addr    = p_reg[GW+1:2];
        wr_en      = 1'b0;
        wr_addr    = p_reg[GW+1:2];
        wr_data    = {1'b0, hsize_reg[SW-1:0]};

        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = (clr_reg == '0) ? {1'b1, INIT_SIZE} : '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    need_next = (PW'(request_size) + RMASK) & ~RMASK;
                    ok_next    = 1'b0;
                    boff_next  = '0;
                    msize_next = '0;
                    if (op == ffha_pkg::OP_ALLOC) begin
                        p_next     = '0;
                        state_next = ST_A_RD;
                    end else if (off_al == '0 || off_al < HDR || off_al >= LIMIT) begin
                        done_next = 1'b1;
                    end else begin
                        p_next     = off_al - HDR;
                        state_next = ST_F_RD;
                    end
                end
            end
            ST_A_RD: begin
                rd_addr = p_reg[GW+1:2];
                if (p_reg >= HEAP) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_A_CHK;
                end
            end
            ST_A_CHK: begin
                if (rd_free && rd_size >= need_reg) begin
                    hsize_next = rd_size;
                    if (rd_size > need_reg + HDR) begin
                        hsize_next = need_reg;
                        if (split_pos < HEAP) begin
                            wr_en   = 1'b1;
                            wr_addr = split_pos[GW+1:2];
                            wr_data = {1'b1, SW'(rd_size - need_reg - HDR)};
                        end
                    end
                    state_next = ST_A_MARK;
                end else begin
                    p_next     = p_reg + HDR + rd_size;
                    state_next = ST_A_RD;
                end
            end
            ST_A_MARK: begin
                wr_en      = 1'b1;
                wr_data    = {1'b0, hsize_reg[SW-1:0]};
                ok_next    = 1'b1;
                boff_next  = ffha_pkg::OUT_W'(p_reg + HDR);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_F_RD: begin
                rd_addr    = p_reg[GW+1:2];
                state_next = ST_F_HD;
            end
            ST_F_HD: begin
                hsize_next = rd_size;
                nx_next    = p_reg + HDR + rd_size;
                state_next = ST_F_NRD;
            end
            ST_F_NRD: begin
                rd_addr = nx_reg[GW+1:2];
                if (nx_reg >= HEAP) begin
                    state_next = ST_F_WR;
                end else begin
                    state_next = ST_F_NCHK;
                end
            end
            ST_F_NCHK: begin
                if (rd_free) begin
                    hsize_next = merge_size;
                    nx_next    = p_reg + HDR + merge_size;
                    state_next = ST_F_NRD;
                end else begin
                    state_next = ST_F_WR;
                end
            end
            ST_F_WR: begin
                wr_en      = 1'b1;
                wr_data    = {1'b1, hsize_reg[SW-1:0]};
                ok_next    = 1'b1;
                msize_next = hsize_reg[ffha_pkg::OUT_W-1:0];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            boff_reg  <= '0;
            msize_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
            boff_reg  <= boff_next;
            msize_reg <= msize_next;
        end
    end

    always_ff @(posedge clk) begin
        p_reg     <= p_next;
        nx_reg    <= nx_next;
        need_reg  <= need_next;
        hsize_reg <= hsize_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign ok           = ok_reg;
    assign block_offset = boff_reg;
    assign merged_size  = msize_reg;

    // A result is only given once the sequencer is back to waiting.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // A failed transaction reports no offset and no size.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ok |-> block_offset == '0 && merged_size == '0)
        else $error("failed transaction carries nonzero payload");

    // An accepted transaction either answers at once or keeps the block busy.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted transaction dropped");

    // An allocate never reports a merged size, and a free never an offset.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> block_offset == '0 || merged_size == '0)
        else $error("both offset and merged size reported");

endmodule

`default_nettype wire
